>>> design/i2cms_pkg.sv
`timescale 1ns / 1ps

package i2cms_pkg;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_START = 2'd2,
    OP_EVENT = 2'd3
  } op_e;

  typedef enum logic [0:0] {
    CFG_SLAVE_ADDR = 1'b0,
    CFG_SEND_STOP  = 1'b1
  } cfg_e;

  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 8;
  localparam int unsigned LevelW   = 5;

  localparam logic [7:0] ST_START      = 8'h08;
  localparam logic [7:0] ST_REP_START  = 8'h10;
  localparam logic [7:0] ST_MT_SLA_ACK = 8'h18;
  localparam logic [7:0] ST_MT_DAT_ACK = 8'h28;
  localparam logic [7:0] ST_ARB_LOST   = 8'h38;
  localparam logic [7:0] ST_MR_SLA_ACK = 8'h40;
  localparam logic [7:0] ST_MR_DAT_ACK = 8'h50;
  localparam logic [7:0] ST_MR_DAT_NAK = 8'h58;

  typedef struct packed {
    logic              ctl_valid;
    logic              ctl_go;
    logic              ctl_ack;
    logic              ctl_start;
    logic              ctl_stop;
    logic              ctl_irq_en;
    logic              load_data;
    logic [7:0]        bus_tx_data;
    logic [7:0]        host_rx_byte;
    logic [LevelW-1:0] fifo_level;
    logic              done_res;
    logic              data_ready;
  } res_t;

  typedef struct packed {
    logic tx_from_fifo;
    logic host_from_fifo;
  } sel_t;

endpackage

>>> design/i2cms_req_if.sv
`timescale 1ns / 1ps

interface i2cms_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [7:0]  tx_byte;
  logic        read_dir;
  logic [15:0] read_count;
  logic [7:0]  bus_status;
  logic [7:0]  bus_rx_data;

  modport source (
    output valid, op, tx_byte, read_dir, read_count, bus_status, bus_rx_data,
    input  ready
  );
  modport sink (
    input  valid, op, tx_byte, read_dir, read_count, bus_status, bus_rx_data,
    output ready
  );
endinterface

>>> design/i2cms_rsp_if.sv
`timescale 1ns / 1ps

interface i2cms_rsp_if;
  logic       valid;
  logic       ready;
  logic       ctl_valid;
  logic       ctl_go;
  logic       ctl_ack;
  logic       ctl_start;
  logic       ctl_stop;
  logic       ctl_irq_en;
  logic       load_data;
  logic [7:0] bus_tx_data;
  logic [7:0] host_rx_byte;
  logic [4:0] fifo_level;
  logic       done_res;
  logic       data_ready;

  modport source (
    output valid, ctl_valid, ctl_go, ctl_ack, ctl_start, ctl_stop, ctl_irq_en,
           load_data, bus_tx_data, host_rx_byte, fifo_level, done_res, data_ready,
    input  ready
  );
  modport sink (
    input  valid, ctl_valid, ctl_go, ctl_ack, ctl_start, ctl_stop, ctl_irq_en,
           load_data, bus_tx_data, host_rx_byte, fifo_level, done_res, data_ready,
    output ready
  );
endinterface

>>> design/i2c_master_status_sequencer.sv
`timescale 1ns / 1ps

// I2C master byte-level sequencer.
// The request channel carries host operations (push a transmit byte, pop a
// received byte, start a transfer) and bus status events from the byte
// engine. Every accepted request yields exactly one result on the response
// channel: the next bus control word, the byte to load into the shifter,
// the byte popped for the host, the FIFO level and the done and ready flags.
// Registers are to be written through the configuration port while idle; the
// block does not enforce this. Control state updates in the cycle a request
// is accepted, and the shared byte FIFO is a synchronous memory read in that
// same cycle. The response is held in the middle stage with the memory read,
// then in the output register. One request is accepted per cycle while the
// receiver does not stall. If it stalls, one more request is taken into the
// middle stage before the request channel stalls. Reset empties the FIFO
// pointers, clears all flags and both configuration registers, and drops
// all pending results; the FIFO storage itself is not cleared.

module i2c_master_status_sequencer #(
  parameter int unsigned FIFO_DEPTH = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  i2cms_req_if.sink                         req_i,
  i2cms_rsp_if.source                       rsp_o,
  input  logic                              cfg_we_i,
  input  logic [i2cms_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [i2cms_pkg::CfgDataW-1:0]    cfg_data_i
);

  import i2cms_pkg::*;

  localparam int unsigned PtrW = $clog2(FIFO_DEPTH);
  localparam int unsigned CntW = $clog2(FIFO_DEPTH + 1);

  logic [7:0]      slave_addr_q;
  logic            send_stop_q;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [15:0]     left_q, left_d;
  logic            reading_q, reading_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic            rdy_q, rdy_d;

  logic            accept;
  logic            put_en, get_en;
  logic [7:0]      put_data;
  logic            fifo_full, fifo_empty;
  logic [7:0]      mem_rdata;
  res_t            res_s1;
  sel_t            sel_s1;

  logic            a_valid_q;
  res_t            a_res_q;
  sel_t            a_sel_q;
  res_t            a_res;
  logic            a_move;
  logic            b_valid_q;
  res_t            b_res_q;

  assign accept     = req_i.valid && req_i.ready;
  assign fifo_full  = (cnt_q == CntW'(FIFO_DEPTH));
  assign fifo_empty = (cnt_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slave_addr_q <= '0;
      send_stop_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_e'(cfg_idx_i))
        CFG_SLAVE_ADDR: slave_addr_q <= cfg_data_i;
        CFG_SEND_STOP:  send_stop_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    rd_ptr_d  = rd_ptr_q;
    wr_ptr_d  = wr_ptr_q;
    cnt_d     = cnt_q;
    left_d    = left_q;
    reading_d = reading_q;
    busy_d    = busy_q;
    done_d    = done_q;
    rdy_d     = rdy_q;
    put_en    = 1'b0;
    get_en    = 1'b0;
    put_data  = req_i.tx_byte;
    res_s1    = '0;
    sel_s1    = '0;

    unique case (op_e'(req_i.op))
      OP_PUSH: begin
        if (!fifo_full) begin
          put_en = 1'b1;
          if (!busy_q && !reading_q && !done_q) begin
            res_s1.ctl_valid  = 1'b1;
            res_s1.ctl_go     = 1'b1;
            res_s1.ctl_start  = 1'b1;
            res_s1.ctl_irq_en = 1'b1;
            busy_d            = 1'b1;
          end
        end
      end
      OP_POP: begin
        if (!fifo_empty) begin
          get_en                = 1'b1;
          sel_s1.host_from_fifo = 1'b1;
        end
      end
      OP_START: begin
        if (!busy_q) begin
          rd_ptr_d  = '0;
          wr_ptr_d  = '0;
          cnt_d     = '0;
          done_d    = 1'b0;
          rdy_d     = 1'b0;
          reading_d = req_i.read_dir;
          if (req_i.read_dir) begin
            left_d            = req_i.read_count;
            res_s1.ctl_valid  = 1'b1;
            res_s1.ctl_go     = 1'b1;
            res_s1.ctl_start  = 1'b1;
            res_s1.ctl_irq_en = 1'b1;
            busy_d            = 1'b1;
          end else begin
            left_d = '0;
          end
        end
      end
      OP_EVENT: begin
        if (busy_q) begin
          res_s1.ctl_valid = 1'b1;
          put_data         = req_i.bus_rx_data;
          unique case (req_i.bus_status)
            ST_START, ST_REP_START: begin
              res_s1.load_data   = 1'b1;
              res_s1.bus_tx_data = {slave_addr_q[7:1], reading_q};
              res_s1.ctl_go      = 1'b1;
              res_s1.ctl_irq_en  = 1'b1;
            end
            ST_MT_SLA_ACK, ST_MT_DAT_ACK: begin
              if (!fifo_empty) begin
                get_en              = 1'b1;
                sel_s1.tx_from_fifo = 1'b1;
                res_s1.load_data    = 1'b1;
                res_s1.ctl_go       = 1'b1;
                res_s1.ctl_irq_en   = 1'b1;
              end else begin
                done_d          = 1'b1;
                res_s1.ctl_go   = send_stop_q;
                res_s1.ctl_stop = send_stop_q;
                busy_d          = 1'b0;
              end
            end
            ST_MR_DAT_ACK: begin
              put_en = !fifo_full;
              if (left_q != '0) begin
                left_d = left_q - 16'd1;
              end
              res_s1.ctl_ack    = (left_d > 16'd1);
              res_s1.ctl_go     = 1'b1;
              res_s1.ctl_irq_en = 1'b1;
            end
            ST_MR_SLA_ACK: begin
              res_s1.ctl_ack    = (left_q > 16'd1);
              res_s1.ctl_go     = 1'b1;
              res_s1.ctl_irq_en = 1'b1;
            end
            ST_MR_DAT_NAK: begin
              put_en = !fifo_full;
              if (left_q != '0) begin
                left_d = left_q - 16'd1;
              end
              done_d          = 1'b1;
              rdy_d           = 1'b1;
              res_s1.ctl_go   = send_stop_q;
              res_s1.ctl_stop = send_stop_q;
              busy_d          = 1'b0;
            end
            ST_ARB_LOST: begin
              res_s1.ctl_go     = 1'b1;
              res_s1.ctl_start  = 1'b1;
              res_s1.ctl_irq_en = 1'b1;
            end
            default: begin
              busy_d = 1'b0;
            end
          endcase
        end
      end
      default: ;
    endcase

    if (put_en) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      cnt_d    = cnt_q + 1'b1;
    end
    if (get_en) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      cnt_d    = cnt_q - 1'b1;
    end

    res_s1.fifo_level = LevelW'(cnt_d);
    res_s1.done_res   = done_d;
    res_s1.data_ready = rdy_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q  <= '0;
      wr_ptr_q  <= '0;
      cnt_q     <= '0;
      left_q    <= '0;
      reading_q <= 1'b0;
      busy_q    <= 1'b0;
      done_q    <= 1'b0;
      rdy_q     <= 1'b0;
    end else if (accept) begin
      rd_ptr_q  <= rd_ptr_d;
      wr_ptr_q  <= wr_ptr_d;
      cnt_q     <= cnt_d;
      left_q    <= left_d;
      reading_q <= reading_d;
      busy_q    <= busy_d;
      done_q    <= done_d;
      rdy_q     <= rdy_d;
    end
  end

  i2cms_fifo_mem #(
    .Depth (FIFO_DEPTH),
    .AddrW (PtrW)
  ) u_fifo_mem (
    .clk_i   (clk_i),
    .we_i    (accept && put_en),
    .waddr_i (wr_ptr_q),
    .wdata_i (put_data),
    .re_i    (accept && get_en),
    .raddr_i (rd_ptr_q),
    .rdata_o (mem_rdata)
  );

  assign a_move      = a_valid_q && (!b_valid_q || rsp_o.ready);
  assign req_i.ready = !a_valid_q || a_move;

  always_comb begin
    a_res = a_res_q;
    if (a_sel_q.tx_from_fifo) begin
      a_res.bus_tx_data = mem_rdata;
    end
    if (a_sel_q.host_from_fifo) begin
      a_res.host_rx_byte = mem_rdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        a_valid_q <= 1'b1;
      end else if (a_move) begin
        a_valid_q <= 1'b0;
      end
      if (a_move) begin
        b_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        b_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_res_q <= res_s1;
      a_sel_q <= sel_s1;
    end
    if (a_move) begin
      b_res_q <= a_res;
    end
  end

  assign rsp_o.valid        = b_valid_q;
  assign rsp_o.ctl_valid    = b_res_q.ctl_valid;
  assign rsp_o.ctl_go       = b_res_q.ctl_go;
  assign rsp_o.ctl_ack      = b_res_q.ctl_ack;
  assign rsp_o.ctl_start    = b_res_q.ctl_start;
  assign rsp_o.ctl_stop     = b_res_q.ctl_stop;
  assign rsp_o.ctl_irq_en   = b_res_q.ctl_irq_en;
  assign rsp_o.load_data    = b_res_q.load_data;
  assign rsp_o.bus_tx_data  = b_res_q.bus_tx_data;
  assign rsp_o.host_rx_byte = b_res_q.host_rx_byte;
  assign rsp_o.fifo_level   = b_res_q.fifo_level;
  assign rsp_o.done_res     = b_res_q.done_res;
  assign rsp_o.data_ready   = b_res_q.data_ready;

endmodule

>>> design/i2cms_fifo_mem.sv
`timescale 1ns / 1ps

module i2cms_fifo_mem #(
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = 4
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [7:0]       wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [7:0]       rdata_o
);

  logic [7:0] mem [Depth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/i2cms_checker.sv
`timescale 1ns / 1ps

module i2cms_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       rsp_valid_i,
  input logic       rsp_ready_i,
  input logic       ctl_valid_i,
  input logic       ctl_go_i,
  input logic       ctl_ack_i,
  input logic       ctl_start_i,
  input logic       ctl_stop_i,
  input logic       ctl_irq_en_i,
  input logic       load_data_i,
  input logic [7:0] bus_tx_data_i,
  input logic       done_res_i,
  input logic       data_ready_i
);

  logic [6:0] ctl_word;

  assign ctl_word = {ctl_go_i, ctl_ack_i, ctl_start_i, ctl_stop_i, ctl_irq_en_i,
                     load_data_i, ctl_valid_i};

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !ctl_valid_i |->
      !(ctl_go_i || ctl_ack_i || ctl_start_i || ctl_stop_i || ctl_irq_en_i || load_data_i))
    else $error("Control bits set without a control word.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !load_data_i |-> bus_tx_data_i == 8'h00)
    else $error("Transmit byte nonzero without a load.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && data_ready_i |-> done_res_i)
    else $error("Read data ready without the transfer done.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && ctl_stop_i |-> !ctl_start_i && !ctl_irq_en_i && ctl_go_i)
    else $error("Stop issued together with start or with events enabled.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(ctl_word))
    else $error("Stalled response changed.");

endmodule

bind i2c_master_status_sequencer i2cms_checker u_i2cms_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .ctl_valid_i   (rsp_o.ctl_valid),
  .ctl_go_i      (rsp_o.ctl_go),
  .ctl_ack_i     (rsp_o.ctl_ack),
  .ctl_start_i   (rsp_o.ctl_start),
  .ctl_stop_i    (rsp_o.ctl_stop),
  .ctl_irq_en_i  (rsp_o.ctl_irq_en),
  .load_data_i   (rsp_o.load_data),
  .bus_tx_data_i (rsp_o.bus_tx_data),
  .done_res_i    (rsp_o.done_res),
  .data_ready_i  (rsp_o.data_ready)
);
